// ----- rtl/uart_8n1_bit_timed_transceiver_core_macros.svh -----
// assertion macros used by the transceiver top level
`ifndef UART_8N1_BIT_TIMED_TRANSCEIVER_CORE_MACROS_SVH
`define UART_8N1_BIT_TIMED_TRANSCEIVER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define UART8N1_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UART8N1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/uart8n1_pkg.sv -----
// shared types and constants of the uart 8n1 transceiver
package uart8n1_pkg;

	localparam int TIMER_BITS_DEF = 24;

	localparam int PERIOD_W  = 24;
	localparam int TIMEOUT_W = 31;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 8'd1;

	localparam logic [PERIOD_W-1:0]  BIT_PERIOD_RST    = 24'd1250;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_LIMIT_RST = 31'h7ffff000;

	// start + 8 data + stop
	localparam logic [3:0] FRAME_BITS = 4'd10;
	localparam logic [3:0] DATA_BITS  = 4'd8;

	typedef struct packed {
		logic       rx_line;
		logic       send;
		logic [7:0] send_byte;
		logic       listen;
	} tick_t;

	typedef struct packed {
		logic       tx_line;
		logic       tx_busy;
		logic       rx_busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_timeout;
	} result_t;

	typedef struct packed {
		logic line;
		logic busy;
	} tx_stat_t;

	typedef struct packed {
		logic       busy;
		logic       valid;
		logic [7:0] data;
		logic       timeout;
	} rx_stat_t;

endpackage

// ----- rtl/uart8n1_if.sv -----
// handshake channels of the uart 8n1 transceiver

interface uart8n1_tick_if;
	logic                 valid;
	logic                 ready;
	uart8n1_pkg::tick_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface uart8n1_result_if;
	logic                 valid;
	logic                 ready;
	uart8n1_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface uart8n1_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [uart8n1_pkg::CFG_IDX_W-1:0]    idx;
	logic [uart8n1_pkg::CFG_DATA_W-1:0]   wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink   (input valid, input idx, input wdata, output ready);
endinterface

// ----- rtl/uart8n1_tx.sv -----
// transmit side: frame shifter and bit timer
module uart8n1_tx #(
	parameter int TIMER_BITS = uart8n1_pkg::TIMER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       send,
	input  logic [7:0]                 send_byte,
	input  logic [TIMER_BITS-1:0]      period,
	output uart8n1_pkg::tx_stat_t      stat
);

	logic [9:0]            frame_q, frame_d;
	logic [3:0]            bits_left_q, bits_left_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  level_q, level_d;

	always_comb begin
		frame_d     = frame_q;
		bits_left_d = bits_left_q;
		timer_d     = timer_q;
		level_d     = level_q;
		if (bits_left_q != 4'd0) begin
			if (timer_q >= period) begin
				timer_d     = TIMER_BITS'(1);
				frame_d     = {1'b0, frame_q[9:1]};
				bits_left_d = bits_left_q - 4'd1;
				// line goes idle once the stop bit has run out
				level_d     = (bits_left_d == 4'd0) ? 1'b1 : frame_d[0];
			end else begin
				timer_d = timer_q + TIMER_BITS'(1);
			end
		end else if (send) begin
			frame_d     = {1'b1, send_byte, 1'b0};
			bits_left_d = uart8n1_pkg::FRAME_BITS;
			timer_d     = TIMER_BITS'(1);
			level_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			bits_left_q <= '0;
			timer_q     <= '0;
			level_q     <= 1'b1;
		end else if (step) begin
			frame_q     <= frame_d;
			bits_left_q <= bits_left_d;
			timer_q     <= timer_d;
			level_q     <= level_d;
		end
	end

	assign stat.line = level_d;
	assign stat.busy = (bits_left_d != 4'd0);

endmodule

// ----- rtl/uart8n1_rx.sv -----
// receive side: start wait with timeout, mid-bit sampler
module uart8n1_rx #(
	parameter int TIMER_BITS = uart8n1_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                rx_line,
	input  logic                                listen,
	input  logic [TIMER_BITS-1:0]               period,
	input  logic [TIMER_BITS:0]                 first_target,
	input  logic [uart8n1_pkg::TIMEOUT_W-1:0]   timeout_limit,
	output uart8n1_pkg::rx_stat_t               stat
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_HIGH,
		PH_WAIT_EDGE,
		PH_SAMPLE
	} phase_t;

	phase_t                              phase_q, phase_d;
	logic [TIMER_BITS:0]                 timer_q, timer_d, timer_inc, target;
	logic [7:0]                          shift_q, shift_d;
	logic [3:0]                          taken_q, taken_d;
	logic [uart8n1_pkg::TIMEOUT_W-1:0]   wait_q, wait_d;
	logic                                got_byte, timed_out;

	// first sample lands half a period past the first full bit
	assign target    = (taken_q == 4'd0) ? first_target : {1'b0, period};
	assign timer_inc = timer_q + (TIMER_BITS+1)'(1);

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		shift_d   = shift_q;
		taken_d   = taken_q;
		wait_d    = wait_q;
		got_byte  = 1'b0;
		timed_out = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (listen) begin
					phase_d = PH_WAIT_HIGH;
					wait_d  = '0;
				end
			end
			PH_WAIT_HIGH, PH_WAIT_EDGE: begin
				if (rx_line) begin
					phase_d = PH_WAIT_EDGE;
					if (wait_q >= timeout_limit) begin
						timed_out = 1'b1;
						phase_d   = PH_IDLE;
					end else begin
						wait_d = wait_q + uart8n1_pkg::TIMEOUT_W'(1);
					end
				end else if (phase_q == PH_WAIT_EDGE) begin
					phase_d = PH_SAMPLE;
					timer_d = '0;
					shift_d = '0;
					taken_d = '0;
				end
			end
			PH_SAMPLE: begin
				if (timer_inc >= target) begin
					timer_d = '0;
					shift_d = {rx_line, shift_q[7:1]};
					taken_d = taken_q + 4'd1;
					if (taken_d >= uart8n1_pkg::DATA_BITS) begin
						got_byte = 1'b1;
						phase_d  = PH_IDLE;
					end
				end else begin
					timer_d = timer_inc;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			taken_q <= '0;
			wait_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			shift_q <= shift_d;
			taken_q <= taken_d;
			wait_q  <= wait_d;
		end
	end

	assign stat.busy    = (phase_d != PH_IDLE);
	assign stat.valid   = got_byte;
	assign stat.data    = got_byte ? shift_d : 8'd0;
	assign stat.timeout = timed_out;

endmodule

// ----- rtl/uart_8n1_bit_timed_transceiver_core.sv -----
// top level of the bit-timed uart 8n1 transceiver
//
// tick channel: one beat per clock tick of bit timing, carrying the sampled
// rx line, a transmit request with its byte, and a request to arm the receiver.
// result channel: one beat per tick beat, with the tx line level, busy flags,
// and a received byte or a start-wait timeout on the tick they occur.
// cfg channel: always ready; index 0 writes bit_period, index 1 timeout_limit,
// other indexes are dropped. write only while no tick beat is in flight.
// path: an accepted tick beat passes two registers, the tick register and
// then the result register, before it shows up on the result channel.
// throughput: one tick beat per cycle while result beats are taken; tx and rx
// each update their state straight from the tick register, so nothing iterates.
// stall: while a result beat waits, the tick register can still take one
// more beat; after that tick ready drops until the result is taken. state only
// advances when a result beat is produced, so stalls never change timing.
// reset: tx line idle high, both sides idle, bit period and timeout limit at their reset values.
`include "uart_8n1_bit_timed_transceiver_core_macros.svh"

module uart_8n1_bit_timed_transceiver_core #(
	parameter int TIMER_BITS = uart8n1_pkg::TIMER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	uart8n1_tick_if.sink            tick,
	uart8n1_result_if.source        result,
	uart8n1_cfg_if.sink             cfg
);

	localparam logic [TIMER_BITS-1:0] RST_PERIOD = TIMER_BITS'(uart8n1_pkg::BIT_PERIOD_RST);
	localparam logic [TIMER_BITS:0]   RST_FIRST  =
		{1'b0, RST_PERIOD} + (TIMER_BITS+1)'(RST_PERIOD >> 1);

	logic [uart8n1_pkg::PERIOD_W-1:0]  bit_period_q;
	logic [uart8n1_pkg::TIMEOUT_W-1:0] timeout_limit_q;
	logic [TIMER_BITS:0]               first_target_q;
	logic [TIMER_BITS-1:0]             wr_period, period;
	logic [TIMER_BITS:0]               wr_first;

	logic                  valid_s1;
	uart8n1_pkg::tick_t    tick_s1;
	logic                  out_valid_q;
	uart8n1_pkg::result_t  out_q;
	logic                  adv, step;
	uart8n1_pkg::tx_stat_t tx_stat;
	uart8n1_pkg::rx_stat_t rx_stat;

	// configuration
	assign cfg.ready = 1'b1;
	assign wr_period = TIMER_BITS'(cfg.wdata[uart8n1_pkg::PERIOD_W-1:0]);
	assign wr_first  = {1'b0, wr_period} + (TIMER_BITS+1)'(wr_period >> 1);
	assign period    = TIMER_BITS'(bit_period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q    <= uart8n1_pkg::BIT_PERIOD_RST;
			timeout_limit_q <= uart8n1_pkg::TIMEOUT_LIMIT_RST;
			first_target_q  <= RST_FIRST;
		end else if (cfg.valid) begin
			case (cfg.idx)
				uart8n1_pkg::REG_BIT_PERIOD: begin
					bit_period_q   <= cfg.wdata[uart8n1_pkg::PERIOD_W-1:0];
					first_target_q <= wr_first;
				end
				uart8n1_pkg::REG_TIMEOUT_LIMIT: begin
					timeout_limit_q <= cfg.wdata[uart8n1_pkg::TIMEOUT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// tick register and result register
	assign adv        = !out_valid_q || result.ready;
	assign step       = valid_s1 && adv;
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.valid && tick.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
		if (step) begin
			out_q.tx_line    <= tx_stat.line;
			out_q.tx_busy    <= tx_stat.busy;
			out_q.rx_busy    <= rx_stat.busy;
			out_q.rx_valid   <= rx_stat.valid;
			out_q.rx_byte    <= rx_stat.data;
			out_q.rx_timeout <= rx_stat.timeout;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	uart8n1_tx #(
		.TIMER_BITS(TIMER_BITS)
	) u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.send      (tick_s1.send),
		.send_byte (tick_s1.send_byte),
		.period    (period),
		.stat      (tx_stat)
	);

	uart8n1_rx #(
		.TIMER_BITS(TIMER_BITS)
	) u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_line       (tick_s1.rx_line),
		.listen        (tick_s1.listen),
		.period        (period),
		.first_target  (first_target_q),
		.timeout_limit (timeout_limit_q),
		.stat          (rx_stat)
	);

	// a byte and a timeout cannot finish on the same tick
	`UART8N1_ASSERT_NOW(a_valid_xor_timeout, out_valid_q, !(out_q.rx_valid && out_q.rx_timeout), "rx byte and timeout together")
	// completion ends the receive, so busy must be low with it
	`UART8N1_ASSERT_NOW(a_done_not_busy, out_valid_q && (out_q.rx_valid || out_q.rx_timeout), !out_q.rx_busy, "rx busy after completion")
	`UART8N1_ASSERT_NOW(a_byte_zero, out_valid_q && !out_q.rx_valid, out_q.rx_byte == 8'd0, "rx byte set without valid")
	// a held tick beat is not lost while the result side stalls
	`UART8N1_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1, "tick register dropped a beat")

endmodule

// ----- test/uart_8n1_bit_timed_transceiver_core_checker.sv -----
// checker for the uart 8n1 transceiver: models every tick beat and compares result beats
module uart_8n1_bit_timed_transceiver_core_checker
	import uart8n1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	uart8n1_tick_if     tick,
	uart8n1_result_if   result,
	uart8n1_cfg_if      cfg,
	output int unsigned fails,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_WAIT_HIGH,
		RX_WAIT_EDGE,
		RX_SAMPLE
	} rx_phase_t;

	// register copies
	logic [PERIOD_W-1:0]  bit_period;
	logic [TIMEOUT_W-1:0] timeout_limit;

	// transmit side
	logic [9:0]          tx_frame;
	logic [3:0]          tx_left;
	logic [PERIOD_W-1:0] tx_timer;
	logic                tx_level;

	// receive side
	rx_phase_t           rx_phase;
	logic [PERIOD_W:0]   rx_timer;
	logic [7:0]          rx_shift;
	logic [3:0]          rx_taken;
	logic [TIMEOUT_W-1:0] rx_wait;

	result_t     due_results[$];
	result_t     oldest;
	int unsigned miss_count;

	assign fails = miss_count;

	function automatic result_t advance_line_tick(input tick_t t);
		result_t         r;
		logic [PERIOD_W:0] target;
		r = '0;

		if (tx_left != 4'd0) begin
			if (tx_timer >= bit_period) begin
				tx_timer = PERIOD_W'(1);
				tx_frame = tx_frame >> 1;
				tx_left  = tx_left - 4'd1;
				tx_level = (tx_left == 4'd0) ? 1'b1 : tx_frame[0];
			end else begin
				tx_timer = tx_timer + PERIOD_W'(1);
			end
		end else if (t.send) begin
			tx_frame = {1'b1, t.send_byte, 1'b0};
			tx_left  = FRAME_BITS;
			tx_timer = PERIOD_W'(1);
			tx_level = 1'b0;
		end

		case (rx_phase)
			RX_IDLE: begin
				if (t.listen) begin
					rx_phase = RX_WAIT_HIGH;
					rx_wait  = '0;
				end
			end
			RX_WAIT_HIGH, RX_WAIT_EDGE: begin
				if (t.rx_line) begin
					// a high tick in wait-for-high already counts toward the edge wait
					if (rx_phase == RX_WAIT_HIGH)
						rx_phase = RX_WAIT_EDGE;
					if (rx_wait >= timeout_limit) begin
						r.rx_timeout = 1'b1;
						rx_phase = RX_IDLE;
					end else begin
						rx_wait = rx_wait + TIMEOUT_W'(1);
					end
				end else if (rx_phase == RX_WAIT_EDGE) begin
					rx_phase = RX_SAMPLE;
					rx_timer = '0;
					rx_shift = '0;
					rx_taken = '0;
				end
			end
			default: begin
				// first sample one and a half periods after the edge
				target = (rx_taken == 4'd0)
					? ((PERIOD_W+1)'(bit_period) + (PERIOD_W+1)'(bit_period >> 1))
					: (PERIOD_W+1)'(bit_period);
				rx_timer = rx_timer + (PERIOD_W+1)'(1);
				if (rx_timer >= target) begin
					rx_timer = '0;
					rx_shift = {t.rx_line, rx_shift[7:1]};
					rx_taken = rx_taken + 4'd1;
					if (rx_taken >= DATA_BITS) begin
						r.rx_valid = 1'b1;
						r.rx_byte  = rx_shift;
						rx_phase   = RX_IDLE;
					end
				end
			end
		endcase

		r.tx_line = tx_level;
		r.tx_busy = (tx_left != 4'd0);
		r.rx_busy = (rx_phase != RX_IDLE);
		return r;
	endfunction

	task automatic match_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			miss_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period    = BIT_PERIOD_RST;
			timeout_limit = TIMEOUT_LIMIT_RST;
			tx_frame = '0;
			tx_left  = '0;
			tx_timer = '0;
			tx_level = 1'b1;
			rx_phase = RX_IDLE;
			rx_timer = '0;
			rx_shift = '0;
			rx_taken = '0;
			rx_wait  = '0;
			due_results.delete();
			miss_count = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_BIT_PERIOD:    bit_period = cfg.wdata[PERIOD_W-1:0];
					REG_TIMEOUT_LIMIT: timeout_limit = cfg.wdata[TIMEOUT_W-1:0];
					default: ;
				endcase
			end
			// a result beat always belongs to an older tick, so compare before pushing
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					miss_count++;
				end else begin
					oldest = due_results.pop_front();
					match_field("tx_line", oldest.tx_line, result.data.tx_line);
					match_field("tx_busy", oldest.tx_busy, result.data.tx_busy);
					match_field("rx_busy", oldest.rx_busy, result.data.rx_busy);
					match_field("rx_valid", oldest.rx_valid, result.data.rx_valid);
					match_field("rx_byte", oldest.rx_byte, result.data.rx_byte);
					match_field("rx_timeout", oldest.rx_timeout, result.data.rx_timeout);
				end
			end
			if (tick.valid && tick.ready)
				due_results.push_back(advance_line_tick(tick.data));
			pending <= due_results.size();
		end
	end

endmodule

// ----- test/uart_8n1_bit_timed_transceiver_core_tb.sv -----
// testbench top for the uart 8n1 transceiver: clock, reset, stimulus and verdict
module uart_8n1_bit_timed_transceiver_core_tb;
	import uart8n1_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF    = 4;
	localparam int          RESET_TICKS = 7;
	localparam int          SETTLE      = 4;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;

	logic clk = 1'b0;
	logic arst_n;

	uart8n1_tick_if   tick_ch();
	uart8n1_result_if result_ch();
	uart8n1_cfg_if    cfg_ch();

	int unsigned fail_count;
	int unsigned pending_beats;
	int unsigned cycle_count = 0;

	// stimulus state
	logic [PERIOD_W-1:0] cur_period = BIT_PERIOD_RST;
	bit          rx_plan[$];
	int unsigned ticks_sent = 0;
	bit          src_steady = 1'b0;
	int unsigned stall_left;
	int unsigned sink_cycles;
	bit          sink_steady;

	always #CLK_HALF clk = ~clk;

	uart_8n1_bit_timed_transceiver_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	uart_8n1_bit_timed_transceiver_core_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.fails   (fail_count),
		.pending (pending_beats)
	);

	// mostly short idle runs, now and then a long one
	function automatic int unsigned idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left  <= 0;
			sink_cycles <= 0;
			sink_steady <= 1'b0;
		end else begin
			sink_cycles <= sink_cycles + 1;
			if (sink_cycles % 256 == 0)
				sink_steady <= ($urandom_range(0, 3) == 0);
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
				result_ch.ready <= 1'b0;
				stall_left <= idle_length() - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic tick_t mk_tick(input logic line, input logic send,
		input logic [7:0] data, input logic listen);
		tick_t t;
		t.rx_line   = line;
		t.send      = send;
		t.send_byte = data;
		t.listen    = listen;
		return t;
	endfunction

	// serial traffic on rx_line at the current bit period (zero taken as one, capped at 48)
	function automatic void plan_rx_traffic();
		int unsigned p;
		logic [7:0]  b;
		bit          lvl;
		p = (cur_period == 0) ? 1 : ((cur_period > 48) ? 48 : cur_period);
		if ($urandom_range(0, 9) < 7) begin
			b = 8'($urandom);
			repeat ($urandom_range(1, 3 * p)) rx_plan.push_back(1'b1);
			repeat (p) rx_plan.push_back(1'b0);
			for (int i = 0; i < 8; i++)
				repeat (p) rx_plan.push_back(b[i]);
			repeat (p) rx_plan.push_back(1'b1);
		end else begin
			// glitches, cut-off frames and long low stretches
			repeat ($urandom_range(1, 6)) begin
				lvl = 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 2 * p + 2)) rx_plan.push_back(lvl);
			end
		end
	endfunction

	function automatic bit next_rx_level();
		if (rx_plan.size() == 0)
			plan_rx_traffic();
		return rx_plan.pop_front();
	endfunction

	function automatic tick_t random_tick();
		return mk_tick(next_rx_level(), $urandom_range(0, 3) == 0, 8'($urandom),
			$urandom_range(0, 2) == 0);
	endfunction

	task automatic put_tick(input tick_t t);
		int unsigned gap;
		if (ticks_sent % 100 == 0)
			src_steady = ($urandom_range(0, 3) == 0);
		ticks_sent++;
		gap = (src_steady || $urandom_range(0, 99) < 55) ? 0 : idle_length();
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data  <= t;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// stop ticks and let every outstanding result drain
	task automatic quiesce();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx   <= idx;
		cfg_ch.wdata <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_BIT_PERIOD)
			cur_period = value[PERIOD_W-1:0];
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] period_w,
		input logic [CFG_DATA_W-1:0] limit_w, input int unsigned items);
		quiesce();
		write_reg(REG_BIT_PERIOD, period_w);
		write_reg(REG_TIMEOUT_LIMIT, limit_w);
		rx_plan.delete();
		repeat (items) put_tick(random_tick());
	endtask

	initial begin
		arst_n = 1'b0;
		tick_ch.valid   = 1'b0;
		tick_ch.data    = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.idx      = '0;
		cfg_ch.wdata    = '0;
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: long bit period, huge timeout
		put_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		put_tick(mk_tick(1'b1, 1'b1, 8'h00, 1'b0));
		put_tick(mk_tick(1'b1, 1'b1, 8'hff, 1'b0)); // dropped, frame in progress
		put_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b1));
		put_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b1)); // dropped, low line keeps waiting
		put_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0));
		put_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0)); // falling edge
		quiesce();
		write_reg(REG_UNMAPPED, $urandom);
		write_reg(REG_BIT_PERIOD, 32'd0);
		write_reg(REG_TIMEOUT_LIMIT, 32'd0);
		// zero period: one sample per tick, tx shifts every tick
		for (int i = 0; i < 8; i++)
			put_tick(mk_tick(1'(8'hc5 >> i), 1'b1, 8'h81, 1'b0));
		put_tick(mk_tick(1'b1, 1'b1, 8'h7e, 1'b1));
		put_tick(mk_tick(1'b1, 1'b1, 8'h7e, 1'b0)); // zero limit times out here
		put_tick(mk_tick(1'b1, 1'b1, 8'h3c, 1'b1));

		run_phase(32'd2, 32'h7fff_ffff, 350);
		run_phase(32'hff00_0003, 32'h8000_0028, 250); // upper bits fall away
		run_phase(32'd1, 32'd6, 120);
		run_phase(32'd5, 32'd0, 250);
		run_phase(32'd7, 32'd200, 330);
		run_phase(32'd4, 32'h7fff_f000, 250);
		run_phase(32'd0, 32'd12, 100);
		run_phase(32'h00ff_ffff, 32'd2, 100);

		quiesce();
		repeat (2 * SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/uart8n1_pkg.sv
rtl/uart8n1_if.sv
rtl/uart8n1_tx.sv
rtl/uart8n1_rx.sv
rtl/uart_8n1_bit_timed_transceiver_core.sv
test/uart_8n1_bit_timed_transceiver_core_checker.sv
test/uart_8n1_bit_timed_transceiver_core_tb.sv
